>>> hw/rtl/swrl_pkg.sv
// shared constants, types and codes for the sliding window rate limiter
package swrl_pkg;

  localparam int unsigned CLIENT_SLOTS = 16;
  localparam int unsigned RING_DEPTH   = 64;
  localparam int unsigned SLOT_W       = $clog2(CLIENT_SLOTS);
  localparam int unsigned PTR_W        = $clog2(RING_DEPTH);
  localparam int unsigned RING_AW      = SLOT_W + PTR_W;
  localparam int unsigned RING_ENTRIES = CLIENT_SLOTS * RING_DEPTH;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned WIN_W    = 24;
  localparam int unsigned MULT_W   = 12;
  localparam int unsigned PROD1_W  = RATE_W + MULT_W;
  localparam int unsigned PROD2_W  = PROD1_W + MULT_W;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned LIMIT_W  = PROD2_W - FRAC_W;
  localparam int unsigned OCC_W    = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE      = 3'd0,
    CFG_RATE        = 3'd1,
    CFG_WINDOW      = 3'd2,
    CFG_MULT_LOW    = 3'd3,
    CFG_MULT_NORMAL = 3'd4,
    CFG_MULT_HIGH   = 3'd5,
    CFG_MULT_CRIT   = 3'd6,
    CFG_LOAD_MULT   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                         enable;
    logic [RATE_W-1:0]            rate;
    logic [WIN_W-1:0]             window;
    logic [3:0][MULT_W-1:0]       prio_mult;
    logic [MULT_W-1:0]            load_mult;
  } cfg_t;

  typedef struct packed {
    logic [PTR_W-1:0]   head;
    logic [PTR_W-1:0]   tail;
    logic [COUNT_W-1:0] count;
  } client_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_POP,
    ST_FINISH
  } state_e;

endpackage

>>> hw/rtl/swrl_cfg_regs.sv
// configuration register file of the rate limiter
module swrl_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [swrl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output swrl_pkg::cfg_t                   cfg_o
);

  swrl_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (swrl_pkg::cfg_idx_e'(cfg_index_i))
        swrl_pkg::CFG_ENABLE:      cfg_d.enable       = cfg_data_i[0];
        swrl_pkg::CFG_RATE:        cfg_d.rate         = cfg_data_i[swrl_pkg::RATE_W-1:0];
        swrl_pkg::CFG_WINDOW:      cfg_d.window       = cfg_data_i[swrl_pkg::WIN_W-1:0];
        swrl_pkg::CFG_MULT_LOW:    cfg_d.prio_mult[0] = cfg_data_i[swrl_pkg::MULT_W-1:0];
        swrl_pkg::CFG_MULT_NORMAL: cfg_d.prio_mult[1] = cfg_data_i[swrl_pkg::MULT_W-1:0];
        swrl_pkg::CFG_MULT_HIGH:   cfg_d.prio_mult[2] = cfg_data_i[swrl_pkg::MULT_W-1:0];
        swrl_pkg::CFG_MULT_CRIT:   cfg_d.prio_mult[3] = cfg_data_i[swrl_pkg::MULT_W-1:0];
        swrl_pkg::CFG_LOAD_MULT:   cfg_d.load_mult    = cfg_data_i[swrl_pkg::MULT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= 1'b1;
      cfg_q.rate      <= swrl_pkg::RATE_W'(60);
      cfg_q.window    <= swrl_pkg::WIN_W'(60000);
      cfg_q.prio_mult <= {4{swrl_pkg::MULT_W'(256)}};
      cfg_q.load_mult <= swrl_pkg::MULT_W'(256);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hw/rtl/swrl_ring_mem.sv
// timestamp ring storage for all clients, one write and one registered read port
module swrl_ring_mem (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [swrl_pkg::RING_AW-1:0]    waddr_i,
  input  logic [swrl_pkg::TIME_W-1:0]     wdata_i,
  input  logic [swrl_pkg::RING_AW-1:0]    raddr_i,
  output logic [swrl_pkg::TIME_W-1:0]     rdata_o
);

  logic [swrl_pkg::TIME_W-1:0] mem_q [swrl_pkg::RING_ENTRIES];
  logic [swrl_pkg::TIME_W-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/swrl_client_mem.sv
// per-client head, tail and counter records with valid bits cleared at reset
module swrl_client_mem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [swrl_pkg::SLOT_W-1:0]    waddr_i,
  input  swrl_pkg::client_rec_t          wdata_i,
  input  logic [swrl_pkg::SLOT_W-1:0]    raddr_i,
  output swrl_pkg::client_rec_t          rdata_o
);

  swrl_pkg::client_rec_t                 mem_q [swrl_pkg::CLIENT_SLOTS];
  logic [swrl_pkg::CLIENT_SLOTS-1:0]     valid_q;
  swrl_pkg::client_rec_t                 rdata_q;
  logic                                  rvalid_q;

  assign rdata_o = rvalid_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

endmodule

>>> hw/rtl/sliding_window_rate_limiter.sv
// sliding window log rate limiter top level: request sequencer and storage
//
// usage: a request beat (client_slot_i, priority_req_i, now_ms_i) is taken at a
// rising edge with start high and busy low. exactly one result beat follows:
// done_o is high for one cycle with allowed_o, window_occupancy_o and
// accepted_total_o, and the receiver takes it at the end of that cycle; the
// receiver cannot stall the block.
// result: done_o follows the READ, CHECK and FINISH states when no expiry scan
// is needed; a scan puts the POP state between CHECK and FINISH.
// busy drops in the result cycle, the earliest in which a new request is taken.
// the record memory read, the two quota multiplies and the ring walk through
// the timestamp memory (one entry per cycle) set this sequence.
// configuration beats (cfg_valid_i, cfg_index_i, cfg_data_i) are taken
// whenever cfg_valid_i is high; cfg_ready_o is always high. write them only
// while the block is idle.
// reset: config and control registers go to their defaults, all client records
// read as empty, requests are taken in the first cycle after. no clearing pass.
module sliding_window_rate_limiter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [3:0]                       client_slot_i,
  input  logic [1:0]                       priority_req_i,
  input  logic [31:0]                      now_ms_i,
  output logic                             done_o,
  output logic                             allowed_o,
  output logic [5:0]                       window_occupancy_o,
  output logic [31:0]                      accepted_total_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [swrl_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  swrl_pkg::cfg_t                        cfg;
  swrl_pkg::state_e                      state_q, state_d;

  logic [swrl_pkg::SLOT_W-1:0]           slot_q, slot_d;
  logic [swrl_pkg::TIME_W-1:0]           now_q, now_d;
  logic [swrl_pkg::TIME_W-1:0]           cutoff_q, cutoff_d;
  logic [swrl_pkg::PROD1_W-1:0]          prod_q, prod_d;
  logic [swrl_pkg::LIMIT_W-1:0]          limit_q, limit_d;
  logic [swrl_pkg::PTR_W-1:0]            head_q, head_d;
  logic [swrl_pkg::PTR_W-1:0]            tail_q, tail_d;
  logic [swrl_pkg::COUNT_W-1:0]          count_q, count_d;

  logic                                  done_q, done_d;
  logic                                  allowed_q, allowed_d;
  logic [swrl_pkg::OCC_W-1:0]            occ_out_q, occ_out_d;
  logic [swrl_pkg::COUNT_W-1:0]          total_q, total_d;

  logic                                  accept;
  logic [swrl_pkg::SLOT_W-1:0]           slot_in;
  logic [swrl_pkg::TIME_W:0]             cut_diff;
  logic [swrl_pkg::PROD2_W-1:0]          prod2;
  logic [swrl_pkg::PTR_W-1:0]            occ;
  logic [swrl_pkg::PTR_W-1:0]            occ_new;
  logic                                  at_limit;
  logic                                  ring_full;
  logic                                  ok;
  logic [swrl_pkg::PTR_W-1:0]            tail_new;
  logic [swrl_pkg::COUNT_W-1:0]          count_new;

  logic                                  rec_we;
  swrl_pkg::client_rec_t                 rec_wdata;
  swrl_pkg::client_rec_t                 rec_rdata;
  logic [swrl_pkg::SLOT_W-1:0]           rec_raddr;

  logic                                  ring_we;
  logic [swrl_pkg::PTR_W-1:0]            ring_rptr;
  logic [swrl_pkg::TIME_W-1:0]           ring_rdata;

  swrl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  swrl_client_mem u_client_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (rec_we),
    .waddr_i (slot_q),
    .wdata_i (rec_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  swrl_ring_mem u_ring_mem (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i ({slot_q, tail_q}),
    .wdata_i (now_q),
    .raddr_i ({slot_q, ring_rptr}),
    .rdata_o (ring_rdata)
  );

  assign busy    = (state_q != swrl_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign slot_in = swrl_pkg::SLOT_W'(client_slot_i);

  assign rec_raddr = slot_in;
  assign cut_diff  = {1'b0, now_ms_i} - {{(swrl_pkg::TIME_W + 1 - swrl_pkg::WIN_W){1'b0}},
                                         cfg.window};
  assign prod2     = swrl_pkg::PROD2_W'(prod_q) * swrl_pkg::PROD2_W'(cfg.load_mult);

  assign occ       = tail_q - head_q;
  assign at_limit  = swrl_pkg::LIMIT_W'(occ) >= limit_q;
  assign ring_full = occ == swrl_pkg::PTR_W'(swrl_pkg::RING_DEPTH - 1);
  assign ok        = !at_limit && !ring_full;
  assign tail_new  = tail_q + swrl_pkg::PTR_W'(1);
  assign count_new = (count_q != '1) ? count_q + swrl_pkg::COUNT_W'(1) : count_q;

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    now_d     = now_q;
    cutoff_d  = cutoff_q;
    prod_d    = prod_q;
    limit_d   = limit_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    done_d    = 1'b0;
    allowed_d = allowed_q;
    occ_out_d = occ_out_q;
    total_d   = total_q;
    rec_we    = 1'b0;
    rec_wdata = '0;
    ring_we   = 1'b0;
    ring_rptr = head_q;
    occ_new   = occ;

    case (state_q)
      swrl_pkg::ST_IDLE: begin
        if (accept) begin
          slot_d   = slot_in;
          now_d    = now_ms_i;
          cutoff_d = cut_diff[swrl_pkg::TIME_W] ? '0 : cut_diff[swrl_pkg::TIME_W-1:0];
          prod_d   = swrl_pkg::PROD1_W'(cfg.rate) *
                     swrl_pkg::PROD1_W'(cfg.prio_mult[priority_req_i]);
          state_d  = swrl_pkg::ST_READ;
        end
      end
      swrl_pkg::ST_READ: begin
        head_d  = rec_rdata.head;
        tail_d  = rec_rdata.tail;
        count_d = rec_rdata.count;
        limit_d = prod2[swrl_pkg::PROD2_W-1:swrl_pkg::FRAC_W];
        state_d = swrl_pkg::ST_CHECK;
      end
      swrl_pkg::ST_CHECK: begin
        // ring read at head is issued here for the expiry scan
        if (cfg.enable && (at_limit || ring_full)) begin
          state_d = swrl_pkg::ST_POP;
        end else begin
          state_d = swrl_pkg::ST_FINISH;
        end
      end
      swrl_pkg::ST_POP: begin
        if (head_q != tail_q && ring_rdata <= cutoff_q) begin
          head_d    = head_q + swrl_pkg::PTR_W'(1);
          ring_rptr = head_d;
        end else begin
          state_d = swrl_pkg::ST_FINISH;
        end
      end
      swrl_pkg::ST_FINISH: begin
        done_d  = 1'b1;
        state_d = swrl_pkg::ST_IDLE;
        if (cfg.enable) begin
          rec_we    = 1'b1;
          ring_we   = ok;
          rec_wdata.head  = head_q;
          rec_wdata.tail  = ok ? tail_new : tail_q;
          rec_wdata.count = ok ? count_new : count_q;
          occ_new   = rec_wdata.tail - head_q;
          allowed_d = ok;
          total_d   = rec_wdata.count;
        end else begin
          allowed_d = 1'b1;
          total_d   = count_q;
        end
        occ_out_d = swrl_pkg::OCC_W'(occ_new);
      end
      default: begin
        state_d = swrl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swrl_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    now_q     <= now_d;
    cutoff_q  <= cutoff_d;
    prod_q    <= prod_d;
    limit_q   <= limit_d;
    head_q    <= head_d;
    tail_q    <= tail_d;
    count_q   <= count_d;
    allowed_q <= allowed_d;
    occ_out_q <= occ_out_d;
    total_q   <= total_d;
  end

  assign done_o             = done_q;
  assign allowed_o          = allowed_q;
  assign window_occupancy_o = occ_out_q;
  assign accepted_total_o   = total_q;

endmodule
